// ----- hw/rtl/producer_consumer_wait_scheduler_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef PRODUCER_CONSUMER_WAIT_SCHEDULER_MACROS_SVH
`define PRODUCER_CONSUMER_WAIT_SCHEDULER_MACROS_SVH

`ifndef SYNTH
`define PCWS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PCWS_ASSERT(lbl, prop, msg) \
  `PCWS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define PCWS_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define PCWS_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/pcws_pkg.sv -----
// Shared types and constants of the producer/consumer wait scheduler.
`default_nettype none

package pcws_pkg;

  localparam int unsigned BufferSlotsDef = 4;
  localparam int unsigned WaitDepthDef   = 8;

  localparam int unsigned IdW      = 8;
  localparam int unsigned CapW     = 3;
  localparam int unsigned FillOutW = 3;

  localparam logic [CapW-1:0] CapReset = 3'd3;

  typedef enum logic [1:0] {
    OUTC_DONE       = 2'd0,
    OUTC_WAIT_FULL  = 2'd1,
    OUTC_WAIT_EMPTY = 2'd2,
    OUTC_DROP       = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [IdW-1:0] process_id;
    logic           is_producer;
  } item_t;

  typedef struct packed {
    logic           push;
    logic           pop;
    logic [IdW-1:0] wr_data;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pcws_if.sv -----
// Valid/ready channel interfaces: arriving processes, dispatch results, capacity writes.
`default_nettype none

interface pcws_in_if
  import pcws_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [IdW-1:0] process_id;
  logic           is_producer;

  modport source (output valid, output process_id, output is_producer, input ready);
  modport sink   (input valid, input process_id, input is_producer, output ready);
endinterface

interface pcws_out_if
  import pcws_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [IdW-1:0]      process_id_res;
  logic                is_producer_res;
  logic [1:0]          outcome;
  logic                was_woken;
  logic [FillOutW-1:0] fill_level;
  logic                last;

  modport source (output valid, output process_id_res, output is_producer_res,
                  output outcome, output was_woken, output fill_level, output last,
                  input ready);
  modport sink   (input valid, input process_id_res, input is_producer_res,
                  input outcome, input was_woken, input fill_level, input last,
                  output ready);
endinterface

interface pcws_cfg_if
  import pcws_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] buffer_capacity;

  modport source (output valid, output buffer_capacity, input ready);
  modport sink   (input valid, input buffer_capacity, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/producer_consumer_wait_scheduler.sv -----
// Producer/consumer wait scheduler: dispatches arrivals against a bounded buffer fill count.
// After an arrival is accepted, the sequencer evaluates it (EVAL) and then presents the result (SEND).
// Each further wakeup dispatch of the chain repeats evaluate, then output handoff (SEND waits for ready).
// An item yielding one result holds the dispatch sequencer through EVAL and SEND; its queue
// of two arrivals keeps accepting meanwhile. Reset clears fill count, wait FIFOs and
// queue; capacity resets to 3. No clearing pass.
`default_nettype none

module producer_consumer_wait_scheduler
  import pcws_pkg::*;
#(
  parameter int unsigned BUFFER_SLOTS = BufferSlotsDef,
  parameter int unsigned WAIT_DEPTH   = WaitDepthDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  pcws_cfg_if.sink    cfg_i,
  pcws_in_if.sink     in_i,
  pcws_out_if.source  out_o
);

  logic [CapW-1:0] cap_q;
  logic            item_valid, item_take;
  item_t           item;
  fifo_ctrl_t      prod_ctrl, cons_ctrl;
  fifo_stat_t      prod_stat, cons_stat;
  logic [IdW-1:0]  prod_rd, cons_rd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.buffer_capacity;
    end
  end

  pcws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  pcws_wait_fifo #(.DEPTH(WAIT_DEPTH)) u_prod_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (prod_ctrl),
    .stat_o    (prod_stat),
    .rd_data_o (prod_rd)
  );

  pcws_wait_fifo #(.DEPTH(WAIT_DEPTH)) u_cons_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cons_ctrl),
    .stat_o    (cons_stat),
    .rd_data_o (cons_rd)
  );

  pcws_back #(
    .BUFFER_SLOTS (BUFFER_SLOTS),
    .WAIT_DEPTH   (WAIT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .prod_ctrl_o  (prod_ctrl),
    .prod_stat_i  (prod_stat),
    .prod_rd_i    (prod_rd),
    .cons_ctrl_o  (cons_ctrl),
    .cons_stat_i  (cons_stat),
    .cons_rd_i    (cons_rd),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/pcws_front.sv -----
// Front end: accepts arriving processes into a two-entry queue for the dispatcher.
`default_nettype none

module pcws_front
  import pcws_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  pcws_in_if.sink in_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  wire   item_take_i
);

  item_t      ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready   = (cnt_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_take_i && item_valid_o;
  assign item_o       = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= '{process_id: in_i.process_id, is_producer: in_i.is_producer};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pcws_wait_fifo.sv -----
// Wait FIFO of blocked process ids, memory based, registered read of the head.
`default_nettype none

`include "producer_consumer_wait_scheduler_macros.svh"

module pcws_wait_fifo
  import pcws_pkg::*;
#(
  parameter int unsigned DEPTH = WaitDepthDef
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire fifo_ctrl_t ctrl_i,
  output fifo_stat_t      stat_o,
  output logic [IdW-1:0]  rd_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IdW-1:0] mem [DEPTH];
  logic [IdW-1:0] rd_q;
  logic [PW-1:0]  head_q, tail_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign do_push      = ctrl_i.push && !stat_o.full;
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign rd_data_o    = rd_q;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem[tail_q] <= ctrl_i.wr_data;
    if (do_pop)  rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) tail_q <= wrap_inc(tail_q);
      if (do_pop)  head_q <= wrap_inc(head_q);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `PCWS_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "wait fifo count above depth")
  `PCWS_ASSERT(a_no_push_pop, !(ctrl_i.push && ctrl_i.pop), "push and pop in one dispatch")
  `PCWS_ASSERT(a_pop_nonempty, ctrl_i.pop |-> !stat_o.empty, "pop of empty wait fifo")

endmodule

`default_nettype wire

// ----- hw/rtl/pcws_back.sv -----
// Back end: dispatch sequencer that runs each arrival and its wakeup chain.
`default_nettype none

`include "producer_consumer_wait_scheduler_macros.svh"

module pcws_back
  import pcws_pkg::*;
#(
  parameter int unsigned BUFFER_SLOTS = BufferSlotsDef,
  parameter int unsigned WAIT_DEPTH   = WaitDepthDef
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire  [CapW-1:0] cap_i,
  input  wire             item_valid_i,
  input  wire item_t      item_i,
  output logic            item_take_o,
  output fifo_ctrl_t      prod_ctrl_o,
  input  wire fifo_stat_t prod_stat_i,
  input  wire [IdW-1:0]   prod_rd_i,
  output fifo_ctrl_t      cons_ctrl_o,
  input  wire fifo_stat_t cons_stat_i,
  input  wire [IdW-1:0]   cons_rd_i,
  pcws_out_if.source      out_o
);

  localparam int unsigned FW      = $clog2(BUFFER_SLOTS + 1);
  localparam int unsigned CMPW    = (FW > CapW) ? FW : CapW;
  localparam int unsigned MAXDISP = 1 + 2 * WAIT_DEPTH;
  localparam int unsigned NW      = $clog2(MAXDISP);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_SEND = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [IdW-1:0]      cur_id_q;
  logic                cur_prod_q, woken_q;
  logic [NW-1:0]       n_q;
  logic [FW-1:0]       fill_q, fill_d;
  logic                more_q, next_prod_q;
  logic [IdW-1:0]      res_id_q;
  logic                res_prod_q, res_woken_q, res_last_q;
  outcome_e            res_outc_q, outc_d;
  logic [FillOutW-1:0] res_fill_q;
  logic                more_raw, more_d, next_prod_d, can_put;

  // usable capacity is min(cap, BUFFER_SLOTS)
  assign can_put = (fill_q < FW'(BUFFER_SLOTS)) && (CMPW'(fill_q) < CMPW'(cap_i));

  always_comb begin
    fill_d      = fill_q;
    outc_d      = OUTC_DONE;
    more_raw    = 1'b0;
    next_prod_d = 1'b0;
    prod_ctrl_o = '{push: 1'b0, pop: 1'b0, wr_data: cur_id_q};
    cons_ctrl_o = '{push: 1'b0, pop: 1'b0, wr_data: cur_id_q};
    if (state_q == ST_EVAL) begin
      if (cur_prod_q) begin
        if (can_put) begin
          fill_d = fill_q + FW'(1);
          if (!cons_stat_i.empty) begin
            cons_ctrl_o.pop = 1'b1;
            more_raw        = 1'b1;
          end
        end else if (!prod_stat_i.full) begin
          prod_ctrl_o.push = 1'b1;
          outc_d           = OUTC_WAIT_FULL;
        end else begin
          outc_d = OUTC_DROP;
        end
      end else begin
        if (fill_q == '0) begin
          if (!cons_stat_i.full) begin
            cons_ctrl_o.push = 1'b1;
            outc_d           = OUTC_WAIT_EMPTY;
          end else begin
            outc_d = OUTC_DROP;
          end
        end else begin
          fill_d = fill_q - FW'(1);
          if (!prod_stat_i.empty) begin
            prod_ctrl_o.pop = 1'b1;
            more_raw        = 1'b1;
            next_prod_d     = 1'b1;
          end
        end
      end
    end
  end

  // chain cut at its length limit; a process popped there is gone
  assign more_d = more_raw && (n_q != NW'(MAXDISP - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (item_valid_i) state_d = ST_EVAL;
      ST_EVAL: state_d = ST_SEND;
      ST_SEND: if (out_o.ready) state_d = more_q ? ST_EVAL : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign item_take_o = (state_q == ST_IDLE) && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      n_q     <= '0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (item_take_o) n_q <= '0;
      else if ((state_q == ST_SEND) && out_o.ready && more_q) n_q <= n_q + NW'(1);
      if (state_q == ST_EVAL) more_q <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      cur_id_q   <= item_i.process_id;
      cur_prod_q <= item_i.is_producer;
      woken_q    <= 1'b0;
    end else if ((state_q == ST_SEND) && out_o.ready && more_q) begin
      cur_id_q   <= next_prod_q ? prod_rd_i : cons_rd_i;
      cur_prod_q <= next_prod_q;
      woken_q    <= 1'b1;
    end
    if (state_q == ST_EVAL) begin
      next_prod_q <= next_prod_d;
      res_id_q    <= cur_id_q;
      res_prod_q  <= cur_prod_q;
      res_outc_q  <= outc_d;
      res_woken_q <= woken_q;
      res_fill_q  <= FillOutW'(fill_d);
      res_last_q  <= !more_d;
    end
  end

  assign out_o.valid           = (state_q == ST_SEND);
  assign out_o.process_id_res  = res_id_q;
  assign out_o.is_producer_res = res_prod_q;
  assign out_o.outcome         = res_outc_q;
  assign out_o.was_woken       = res_woken_q;
  assign out_o.fill_level      = res_fill_q;
  assign out_o.last            = res_last_q;

  `PCWS_ASSERT(a_fill_bound, fill_q <= FW'(BUFFER_SLOTS), "fill count above buffer slots")
  `PCWS_ASSERT(a_first_not_woken, (state_q == ST_EVAL) && (n_q == '0) |-> !woken_q, "first dispatch marked woken")
  `PCWS_ASSERT(a_one_wake, !(prod_ctrl_o.pop && cons_ctrl_o.pop), "two wakeups in one dispatch")

endmodule

`default_nettype wire
